// ===== rtl/mspa_pkg.sv =====
// Shared types, constants and helper functions of the MUSIC pseudospectrum block.
`default_nettype none

package mspa_pkg;

    localparam int MAX_ELEMENTS = 32;
    localparam int GRID_X       = 128;
    localparam int GRID_Y       = 128;
    localparam int COLUMN_SLOTS = 32;
    localparam int CORDIC_STEPS = 16;
    localparam int DIV_STEPS    = 62;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VECTORS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING = 2'd3;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CA,
        S_CB,
        S_MUL1,
        S_MUL2,
        S_ESTART,
        S_ECOR,
        S_MAC,
        S_DEN,
        S_DIV,
        S_SQR,
        S_SQR2,
        S_OUT
    } mspa_state_t;

    function automatic logic signed [17:0] atan_turn(input logic [3:0] i);
        logic signed [17:0] v;
        case (i)
            4'd0:    v = 18'sd8192;
            4'd1:    v = 18'sd4836;
            4'd2:    v = 18'sd2555;
            4'd3:    v = 18'sd1297;
            4'd4:    v = 18'sd651;
            4'd5:    v = 18'sd326;
            4'd6:    v = 18'sd163;
            4'd7:    v = 18'sd81;
            4'd8:    v = 18'sd41;
            4'd9:    v = 18'sd20;
            4'd10:   v = 18'sd10;
            4'd11:   v = 18'sd5;
            4'd12:   v = 18'sd3;
            4'd13:   v = 18'sd1;
            4'd14:   v = 18'sd1;
            default: v = 18'sd0;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] phase_x(input logic [6:0] idx);
        logic [22:0] t;
        t = {idx, 15'b0};
        return 16'(t / GRID_X);
    endfunction

    function automatic logic [15:0] phase_y(input logic [6:0] idx);
        logic [22:0] t;
        t = {idx, 15'b0};
        return 16'(t / GRID_Y);
    endfunction

    function automatic logic signed [15:0] round_q15(input logic signed [33:0] v,
                                                     input logic flip);
        logic signed [33:0] r;
        logic signed [15:0] c;
        r = (v + 34'sd16384) >>> 15;
        if (r > 34'sd32767)
            c = 16'sd32767;
        else if (r < -34'sd32767)
            c = -16'sd32767;
        else
            c = r[15:0];
        return flip ? -c : c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/music_spectrum_planar_array_top.sv =====
// MUSIC pseudospectrum of a rectangular array: subspace store, projection, divide.
//
// Input stream: tuser is the mode (load or evaluate). A load writes one complex
// noise-subspace entry into the store and gives no result. An evaluate gives
// a grid point and yields one result transaction with the Q16.16
// pseudospectrum in tdata and the saturation flag in tuser.
// An evaluate runs the shared 16-step CORDIC once for each grid angle and once
// per element, the per-column multiply-accumulate through the projection memory,
// and the bit-serial divider.
// One evaluate is in flight at a time; tready is high only while idle.
// The result sits in an output register, so a stalled receiver does not block
// the next input transaction; the following result waits until it is taken.
// Reset loads the register defaults and empties the output; the subspace store
// is not cleared and must be loaded before use.
// Configuration writes are taken at any edge with cfg_we high and must only
// happen while the block is idle.
`default_nettype none

module music_spectrum_planar_array_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // element[4:0], vector[9:5], entry_real[25:10], entry_imag[41:26],
    // alpha_index[48:42], beta_index[55:49]
    input  logic [mspa_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // mode[0]
    input  logic [0:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // spectrum[31:0]
    output logic [mspa_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // saturated[0]
    output logic [0:0]                       m_axis_tuser,
    input  logic                             cfg_we,
    input  logic [mspa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mspa_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mspa_pkg::*;

    mspa_state_t state_reg, state_next;

    logic [3:0]  columns_reg;
    logic [2:0]  rows_reg;
    logic [4:0]  vectors_reg;
    logic [15:0] spacing_reg;

    logic [31:0] umem [0:MAX_ELEMENTS*COLUMN_SLOTS-1];
    logic [75:0] pmem [0:COLUMN_SLOTS-1];
    logic [31:0] u_rd_reg;
    logic [75:0] p_rd_reg;

    logic signed [33:0] cx_reg, cy_reg;
    logic signed [17:0] cz_reg;
    logic               cflip_reg;
    logic [4:0]         cstep_reg;
    logic               cor_start;
    logic [15:0]        cor_phase;
    logic               cor_done;
    logic [15:0]        pf;
    logic               fold;
    logic signed [33:0] cdx, cdy;
    logic signed [17:0] catan;
    logic signed [15:0] cos_q, sin_q;

    logic [6:0]         beta_reg;
    logic signed [15:0] ca_reg, sa_reg, cb_reg, sb_reg, ac_reg, as_reg;
    logic signed [32:0] dca_reg, dcb_reg;
    logic signed [48:0] stepx_prod;
    logic [31:0]        stepx_reg, stepy_reg, ph_reg, rowph_reg;
    logic [3:0]         mx, ix_reg;
    logic [2:0]         my, iy_reg;
    logic [4:0]         rc_reg;
    logic [5:0]         m_reg;
    logic               first_reg;
    logic               last_elem;

    logic [5:0]         kiss_reg;
    logic [4:0]         k1_reg, k2_reg;
    logic               v1_reg, v2_reg;
    logic               issue;
    logic               pipe_done;
    logic signed [31:0] rr_reg, ii_reg, ra_reg, ia_reg;
    logic signed [37:0] hpr_reg, hpi_reg;
    logic signed [27:0] da, db;
    logic [55:0]        aa_reg, bb_reg;
    logic [63:0]        den_reg;

    logic [61:0]        num_reg, quo_reg;
    logic [63:0]        rem_reg, rem_sh;
    logic               ge;
    logic [5:0]         dcnt_reg;
    logic [63:0]        sq_reg;
    logic               rbig_reg;
    logic [47:0]        val;
    logic [31:0]        res_data_reg;
    logic               res_sat_reg;

    logic               s_acc;
    logic               out_free;

    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    assign mx = (columns_reg == 4'd0) ? 4'd1 : ((columns_reg > 4'd8) ? 4'd8 : columns_reg);
    assign my = (rows_reg == 3'd0) ? 3'd1 : ((rows_reg > 3'd4) ? 3'd4 : rows_reg);
    assign last_elem = (ix_reg == mx - 4'd1) && (iy_reg == my - 3'd1);

    // CORDIC, one micro-rotation per cycle
    assign cor_done = (cstep_reg == 5'(CORDIC_STEPS));
    assign fold  = (cor_phase >= 16'd16384) && (cor_phase < 16'd49152);
    assign pf    = fold ? (cor_phase - 16'd32768) : cor_phase;
    assign cdx   = cy_reg >>> cstep_reg[3:0];
    assign cdy   = cx_reg >>> cstep_reg[3:0];
    assign catan = atan_turn(cstep_reg[3:0]);
    assign cos_q = round_q15(cx_reg, cflip_reg);
    assign sin_q = round_q15(cy_reg, cflip_reg);

    assign stepx_prod = dca_reg * sb_reg;

    assign issue     = ((state_reg == S_MAC) || (state_reg == S_DEN)) &&
                       (kiss_reg < {1'b0, vectors_reg});
    assign pipe_done = !issue && !v1_reg && !v2_reg;

    assign da = 28'(signed'(p_rd_reg[75:38]) >>> 10);
    assign db = 28'(signed'(p_rd_reg[37:0]) >>> 10);

    assign rem_sh = {rem_reg[62:0], num_reg[61]};
    assign ge     = (rem_sh >= den_reg);
    assign val    = sq_reg[63:16];

    always_comb
    begin
        state_next = state_reg;
        cor_start  = 1'b0;
        cor_phase  = 16'd0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_acc && (s_axis_tuser[0] == MODE_EVAL))
                begin
                    cor_start  = 1'b1;
                    cor_phase  = phase_x(s_axis_tdata[48:42]);
                    state_next = S_CA;
                end
            end
            S_CA:
            begin
                if (cor_done)
                begin
                    cor_start  = 1'b1;
                    cor_phase  = phase_y(beta_reg);
                    state_next = S_CB;
                end
            end
            S_CB:
            begin
                if (cor_done)
                    state_next = S_MUL1;
            end
            S_MUL1:   state_next = S_MUL2;
            S_MUL2:   state_next = S_ESTART;
            S_ESTART:
            begin
                cor_start  = 1'b1;
                cor_phase  = 16'((ph_reg + 32'h8000) >> 16);
                state_next = S_ECOR;
            end
            S_ECOR:
            begin
                if (cor_done)
                    state_next = S_MAC;
            end
            S_MAC:
            begin
                if (pipe_done)
                    state_next = last_elem ? S_DEN : S_ESTART;
            end
            S_DEN:
            begin
                if (pipe_done)
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (dcnt_reg == 6'(DIV_STEPS - 1))
                    state_next = S_SQR;
            end
            S_SQR:    state_next = S_SQR2;
            S_SQR2:   state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            columns_reg   <= 4'd7;
            rows_reg      <= 3'd3;
            vectors_reg   <= 5'd20;
            spacing_reg   <= 16'd8296;
            cstep_reg     <= 5'(CORDIC_STEPS);
            kiss_reg      <= 6'd0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            dcnt_reg      <= 6'd0;
            m_axis_tvalid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_COLUMNS: columns_reg <= cfg_data[3:0];
                    CFG_ROWS:    rows_reg    <= cfg_data[2:0];
                    CFG_VECTORS: vectors_reg <= cfg_data[4:0];
                    CFG_SPACING: spacing_reg <= cfg_data;
                    default:     spacing_reg <= spacing_reg;
                endcase
            end
            if (cor_start)
                cstep_reg <= 5'd0;
            else if (!cor_done)
                cstep_reg <= cstep_reg + 5'd1;
            if (issue)
                kiss_reg <= kiss_reg + 6'd1;
            else if (pipe_done)
                kiss_reg <= 6'd0;
            v1_reg <= issue;
            v2_reg <= v1_reg;
            if (state_reg == S_DIV)
                dcnt_reg <= dcnt_reg + 6'd1;
            else
                dcnt_reg <= 6'd0;
            if (state_reg == S_OUT && out_free)
                m_axis_tvalid <= 1'b1;
            else if (m_axis_tready)
                m_axis_tvalid <= 1'b0;
        end
    end

    // subspace store and projection memory
    always_ff @(posedge clk)
    begin
        if (s_acc && (s_axis_tuser[0] == MODE_LOAD))
            umem[{s_axis_tdata[9:5], s_axis_tdata[4:0]}] <=
                {s_axis_tdata[41:26], s_axis_tdata[25:10]};
        u_rd_reg <= umem[{kiss_reg[4:0], rc_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg && (state_reg == S_MAC))
            pmem[k2_reg] <= {38'(hpr_reg + 38'(rr_reg) + 38'(ii_reg)),
                             38'(hpi_reg + 38'(ra_reg) - 38'(ia_reg))};
        p_rd_reg <= pmem[kiss_reg[4:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cor_start)
        begin
            cx_reg    <= CORDIC_START;
            cy_reg    <= 34'sd0;
            cz_reg    <= 18'(signed'(pf));
            cflip_reg <= fold;
        end
        else if (!cor_done)
        begin
            if (!cz_reg[17])
            begin
                cx_reg <= cx_reg - cdx;
                cy_reg <= cy_reg + cdy;
                cz_reg <= cz_reg - catan;
            end
            else
            begin
                cx_reg <= cx_reg + cdx;
                cy_reg <= cy_reg - cdy;
                cz_reg <= cz_reg + catan;
            end
        end

        if (state_reg == S_IDLE)
            beta_reg <= s_axis_tdata[55:49];
        if (state_reg == S_CA && cor_done)
        begin
            ca_reg <= cos_q;
            sa_reg <= sin_q;
        end
        if (state_reg == S_CB && cor_done)
        begin
            cb_reg <= cos_q;
            sb_reg <= sin_q;
        end
        if (state_reg == S_MUL1)
        begin
            dca_reg <= signed'({1'b0, spacing_reg}) * ca_reg;
            dcb_reg <= signed'({1'b0, spacing_reg}) * cb_reg;
        end
        if (state_reg == S_MUL2)
        begin
            stepx_reg <= stepx_prod[43:12];
            stepy_reg <= {dcb_reg[28:0], 3'b0};
            ph_reg    <= 32'd0;
            rowph_reg <= 32'd0;
            ix_reg    <= 4'd0;
            iy_reg    <= 3'd0;
            rc_reg    <= 5'd0;
            first_reg <= 1'b1;
            den_reg   <= 64'd0;
            m_reg     <= 6'(mx * my);
        end
        if (state_reg == S_ECOR && cor_done)
        begin
            ac_reg <= cos_q;
            as_reg <= sin_q;
        end

        // multiply-accumulate pipeline: read, multiply, add and write back
        k1_reg <= kiss_reg[4:0];
        k2_reg <= k1_reg;
        rr_reg <= signed'(u_rd_reg[15:0]) * ac_reg;
        ii_reg <= signed'(u_rd_reg[31:16]) * as_reg;
        ra_reg <= signed'(u_rd_reg[15:0]) * as_reg;
        ia_reg <= signed'(u_rd_reg[31:16]) * ac_reg;
        hpr_reg <= first_reg ? 38'sd0 : signed'(p_rd_reg[75:38]);
        hpi_reg <= first_reg ? 38'sd0 : signed'(p_rd_reg[37:0]);
        aa_reg <= 56'(da * da);
        bb_reg <= 56'(db * db);
        if (v2_reg && (state_reg == S_DEN))
            den_reg <= den_reg + 64'(aa_reg) + 64'(bb_reg);

        if (state_reg == S_MAC && pipe_done && !last_elem)
        begin
            first_reg <= 1'b0;
            rc_reg    <= rc_reg + 5'd1;
            if (ix_reg == mx - 4'd1)
            begin
                ix_reg    <= 4'd0;
                iy_reg    <= iy_reg + 3'd1;
                rowph_reg <= rowph_reg + stepy_reg;
                ph_reg    <= rowph_reg + stepy_reg;
            end
            else
            begin
                ix_reg <= ix_reg + 4'd1;
                ph_reg <= ph_reg + stepx_reg;
            end
        end

        if (state_reg == S_DEN)
        begin
            num_reg <= {m_reg, 56'd0};
            rem_reg <= 64'd0;
            quo_reg <= 62'd0;
        end
        else if (state_reg == S_DIV)
        begin
            rem_reg <= ge ? (rem_sh - den_reg) : rem_sh;
            quo_reg <= {quo_reg[60:0], ge};
            num_reg <= {num_reg[60:0], 1'b0};
        end
        if (state_reg == S_SQR)
        begin
            sq_reg   <= quo_reg[31:0] * quo_reg[31:0];
            rbig_reg <= |quo_reg[61:32];
        end
        if (state_reg == S_SQR2)
        begin
            res_sat_reg  <= rbig_reg || (|val[47:32]);
            res_data_reg <= (rbig_reg || (|val[47:32])) ? 32'hFFFF_FFFF : val[31:0];
        end
        if (state_reg == S_OUT && out_free)
        begin
            m_axis_tdata    <= res_data_reg;
            m_axis_tuser[0] <= res_sat_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mspa_chk.sv =====
// Port-level checks of the pseudospectrum block, bound to its top level.
`default_nettype none

module mspa_chk (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [0:0]                       s_axis_tuser,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [mspa_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic [0:0]                       m_axis_tuser
);
    import mspa_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == MODE_LOAD)
        |=> !$rose(m_axis_tvalid))
        else $error("load produced a result");

    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == MODE_EVAL)
        |=> !s_axis_tready)
        else $error("evaluate did not occupy the block");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 32'hFFFF_FFFF)
        else $error("saturated result not at full scale");

endmodule

bind music_spectrum_planar_array_top mspa_chk u_mspa_chk (.*);

`default_nettype wire
